[hw/rtl/ctc_greedy_decoder_macros.svh]
// assertion helpers for the greedy decoder, clocked on clk, reset by arst_n
`ifndef CTC_GREEDY_DECODER_MACROS_SVH
`define CTC_GREEDY_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CTCGD_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ctcgd check failed");
// next-cycle implication
`define CTCGD_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ctcgd check failed");
`else
`define CTCGD_ASSERT_IMP(name, ante, cons)
`define CTCGD_ASSERT_NXT(name, ante, cons)
`endif

`endif

[hw/rtl/ctcgd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ctcgd_pkg;

	// parameter defaults
	localparam int DEF_MAX_CLASSES = 8192;
	localparam int DEF_MAX_STEPS   = 1024;
	localparam int DEF_SCORE_BITS  = 16;

	// register and field widths
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 14;
	localparam int CLASS_CFG_W = 14;
	localparam int STEP_CFG_W  = 11;
	localparam int KIND_W      = 2;
	localparam int LABEL_W     = 13;
	localparam int MEAN_W      = 16;
	localparam int RUN_W       = 11;

	localparam logic [RUN_W-1:0]       RUN_MAX  = '1;
	localparam logic [CLASS_CFG_W-1:0] NO_CLASS = '1;

	// register reset values
	localparam logic [CLASS_CFG_W-1:0] CLASS_COUNT_RST = 14'd8192;
	localparam logic [CLASS_CFG_W-1:0] LABEL_COUNT_RST = 14'd8192;
	localparam logic [STEP_CFG_W-1:0]  STEP_COUNT_RST  = 11'd1024;
	localparam logic [STEP_CFG_W-1:0]  GAP_RST         = 11'd2;

	typedef enum logic [KIND_W-1:0] {
		KIND_LABEL = 2'd0,
		KIND_SPACE = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLASS_COUNT   = 2'd0,
		REG_LABEL_COUNT   = 2'd1,
		REG_STEP_COUNT    = 2'd2,
		REG_GAP_THRESHOLD = 2'd3
	} cfg_reg_t;

	// controller to datapath
	typedef struct packed {
		logic  take;
		logic  seq_close;
		kind_t kind;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic row_end;
		logic space;
		logic label;
		logic seq_end;
		logic div_busy;
	} status_t;

endpackage

`default_nettype wire

[hw/rtl/ctc_greedy_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none

// ctc greedy best-path decoder: class scores come in one request per cycle, row by row,
// class_count scores per time step and step_count steps per sequence; the first maximum
// of each row wins, class 0 is blank, and a new non-blank winner below label_count goes
// out as a label result (kind 0); a non-blank winner after a blank run longer than
// gap_threshold, once some label was already sent, is preceded by a space (kind 1); after
// the last row an end result (kind 2, last set) carries the mean label score, rounded
// half up, or 0; inside a row a score is taken every cycle; at a row end the input stalls
// while each result of that row is offered; at the end of a sequence a restoring divider
// produces one quotient bit per cycle before the end result shows; configuration
// registers are written through the cfg port, which is always ready; the user must write
// them only while the block is idle, which the block itself does not enforce
module ctc_greedy_decoder import ctcgd_pkg::*; #(
	parameter int MAX_CLASSES = DEF_MAX_CLASSES,
	parameter int MAX_STEPS   = DEF_MAX_STEPS,
	parameter int SCORE_BITS  = DEF_SCORE_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration write port
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// score input
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [SCORE_BITS-1:0] class_score,
	// result output
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic      [KIND_W-1:0]     token_kind,
	output logic      [LABEL_W-1:0]    label_index,
	output logic      [MEAN_W-1:0]     mean_score,
	output logic                       last
);

	cmd_t    cmd;
	status_t st;

	// registers are plain flops, no wait states
	assign cfg_ready = 1'b1;

	// sequencing of row ends, results and the mean division
	ctcgd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.out_stall  (out_stall),
		.st         (st),
		.cmd        (cmd),
		.in_stall   (in_stall),
		.out_valid  (out_valid),
		.token_kind (token_kind),
		.last       (last)
	);

	// row maximum, sequence counters, score sum and divider
	ctcgd_dp #(
		.MAX_CLASSES (MAX_CLASSES),
		.MAX_STEPS   (MAX_STEPS),
		.SCORE_BITS  (SCORE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.class_score (class_score),
		.cmd         (cmd),
		.st          (st),
		.label_index (label_index),
		.mean_score  (mean_score)
	);

endmodule

`default_nettype wire

[hw/rtl/ctcgd_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module ctcgd_div import ctcgd_pkg::*; #(
	parameter int DVD_W = 27,
	parameter int DVS_W = RUN_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  busy,
	output logic      [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic             zero_q;
	logic [DVS_W:0]   rem_sh;
	logic [DVS_W:0]   diff;
	logic             ge;

	assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};
	assign diff   = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			busy_q <= cnt_q != CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= dividend;
			dvs_q  <= divisor;
			rem_q  <= '0;
			zero_q <= divisor == '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = zero_q ? '0 : dvd_q;

endmodule

`default_nettype wire

[hw/rtl/ctcgd_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module ctcgd_dp import ctcgd_pkg::*; #(
	parameter int MAX_CLASSES = DEF_MAX_CLASSES,
	parameter int MAX_STEPS   = DEF_MAX_STEPS,
	parameter int SCORE_BITS  = DEF_SCORE_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [SCORE_BITS-1:0] class_score,
	input  wire cmd_t                  cmd,
	output status_t                    st,
	output logic      [LABEL_W-1:0]    label_index,
	output logic      [MEAN_W-1:0]     mean_score
);

	localparam int CW    = $clog2(MAX_CLASSES);
	localparam int CCW   = (CLASS_CFG_W > $clog2(MAX_CLASSES + 1)) ?
		CLASS_CFG_W : $clog2(MAX_CLASSES + 1);
	localparam int XW    = (CW > CLASS_CFG_W) ? CW : CLASS_CFG_W;
	localparam int SW    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
	localparam int SCW   = (STEP_CFG_W > $clog2(MAX_STEPS + 1)) ?
		STEP_CFG_W : $clog2(MAX_STEPS + 1);
	localparam int SUM_W = SCORE_BITS + $clog2(MAX_STEPS);
	localparam int DVD_W = SUM_W + 1;

	// configuration
	logic [CLASS_CFG_W-1:0] class_count_q;
	logic [CLASS_CFG_W-1:0] label_count_q;
	logic [STEP_CFG_W-1:0]  step_count_q;
	logic [STEP_CFG_W-1:0]  gap_q;

	// sequence state
	logic [CW-1:0]         cls_pos_q;
	logic [SW-1:0]         step_pos_q;
	logic [SCORE_BITS-1:0] best_score_q;
	logic [CW-1:0]         best_class_q;
	logic [XW-1:0]         prev_q;
	logic [RUN_W-1:0]      blank_run_q;
	logic [RUN_W-1:0]      emit_cnt_q;
	logic [SUM_W-1:0]      sum_q;
	logic [CW-1:0]         label_q;

	logic [CCW-1:0]        cc_ext;
	logic [CCW-1:0]        cls_eff;
	logic [CCW:0]          cls_next;
	logic [SCW-1:0]        sc_ext;
	logic [SCW-1:0]        step_eff;
	logic [SCW:0]          step_next;
	logic                  take_new;
	logic [SCORE_BITS-1:0] cur_score;
	logic [CW-1:0]         cur_class;
	logic [XW-1:0]         cur_ext;
	logic                  blank;
	logic                  div_busy;
	logic [DVD_W-1:0]      dividend;
	logic [DVD_W-1:0]      quotient;
	logic [CW+LABEL_W-1:0]     label_ext;
	logic [DVD_W+MEAN_W-1:0]   mean_ext;

	// effective counts, clamped to the supported range
	always_comb begin
		cc_ext = CCW'(class_count_q);
		if (cc_ext == '0)
			cls_eff = CCW'(1);
		else if (cc_ext > CCW'(MAX_CLASSES))
			cls_eff = CCW'(MAX_CLASSES);
		else
			cls_eff = cc_ext;
		sc_ext = SCW'(step_count_q);
		if (sc_ext == '0)
			step_eff = SCW'(1);
		else if (sc_ext > SCW'(MAX_STEPS))
			step_eff = SCW'(MAX_STEPS);
		else
			step_eff = sc_ext;
	end

	assign cls_next  = (CCW+1)'(cls_pos_q) + (CCW+1)'(1);
	assign step_next = (SCW+1)'(step_pos_q) + (SCW+1)'(1);

	// running first maximum of the row
	assign take_new  = (cls_pos_q == '0) || (class_score > best_score_q);
	assign cur_score = take_new ? class_score : best_score_q;
	assign cur_class = take_new ? cls_pos_q : best_class_q;
	assign cur_ext   = XW'(cur_class);
	assign blank     = cur_class == '0;

	always_comb begin
		st.row_end  = cls_next >= {1'b0, cls_eff};
		st.space    = st.row_end && !blank && (blank_run_q > gap_q) && (emit_cnt_q != '0);
		st.label    = st.row_end && !blank && (cur_ext < XW'(label_count_q)) &&
			(cur_ext != prev_q);
		st.seq_end  = st.row_end && (step_next >= {1'b0, step_eff});
		st.div_busy = div_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_count_q <= CLASS_COUNT_RST;
			label_count_q <= LABEL_COUNT_RST;
			step_count_q  <= STEP_COUNT_RST;
			gap_q         <= GAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CLASS_COUNT:   class_count_q <= cfg_data;
				REG_LABEL_COUNT:   label_count_q <= cfg_data;
				REG_STEP_COUNT:    step_count_q  <= cfg_data[STEP_CFG_W-1:0];
				REG_GAP_THRESHOLD: gap_q         <= cfg_data[STEP_CFG_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_pos_q    <= '0;
			step_pos_q   <= '0;
			best_score_q <= '0;
			best_class_q <= '0;
			prev_q       <= XW'(NO_CLASS);
			blank_run_q  <= '0;
			emit_cnt_q   <= '0;
			sum_q        <= '0;
		end else if (cmd.seq_close) begin
			prev_q      <= XW'(NO_CLASS);
			blank_run_q <= '0;
			emit_cnt_q  <= '0;
			sum_q       <= '0;
		end else if (cmd.take) begin
			best_score_q <= cur_score;
			best_class_q <= cur_class;
			if (!st.row_end) begin
				cls_pos_q <= cls_pos_q + CW'(1);
			end else begin
				cls_pos_q  <= '0;
				step_pos_q <= st.seq_end ? '0 : step_pos_q + SW'(1);
				prev_q     <= cur_ext;
				if (blank)
					blank_run_q <= (blank_run_q < RUN_MAX) ? blank_run_q + RUN_W'(1) :
						blank_run_q;
				else
					blank_run_q <= '0;
				if (st.label) begin
					sum_q      <= sum_q + SUM_W'(cur_score);
					emit_cnt_q <= (emit_cnt_q < RUN_MAX) ? emit_cnt_q + RUN_W'(1) :
						emit_cnt_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && st.label)
			label_q <= cur_class;
	end

	// mean with round half up
	assign dividend = DVD_W'(sum_q) + DVD_W'(emit_cnt_q >> 1);

	ctcgd_div #(
		.DVD_W(DVD_W),
		.DVS_W(RUN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.seq_close),
		.dividend (dividend),
		.divisor  (emit_cnt_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	assign label_ext   = {{LABEL_W{1'b0}}, label_q};
	assign mean_ext    = {{MEAN_W{1'b0}}, quotient};
	assign label_index = (cmd.kind == KIND_LABEL) ? label_ext[LABEL_W-1:0] : '0;
	assign mean_score  = (cmd.kind == KIND_END) ? mean_ext[MEAN_W-1:0] : '0;

endmodule

`default_nettype wire

[hw/rtl/ctcgd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "ctc_greedy_decoder_macros.svh"

module ctcgd_ctrl import ctcgd_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    out_stall,
	input  wire status_t st,
	output cmd_t         cmd,
	output logic         in_stall,
	output logic         out_valid,
	output logic [KIND_W-1:0] token_kind,
	output logic         last
);

	typedef enum logic [2:0] {
		ST_SCAN,
		ST_SPACE,
		ST_LABEL,
		ST_DIV_GO,
		ST_DIV_RUN,
		ST_END
	} state_t;

	state_t state_q, state_d;
	logic   pend_label_q, pend_end_q;
	logic   out_valid_q, last_q;
	kind_t  kind_q, kind_d;
	logic   take, out_fire, any_result;

	assign take       = (state_q == ST_SCAN) && in_valid;
	assign out_fire   = out_valid_q && !out_stall;
	assign any_result = st.space || st.label || st.seq_end;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_SCAN: begin
				if (take && st.row_end) begin
					priority if (st.space)   state_d = ST_SPACE;
					else if (st.label)       state_d = ST_LABEL;
					else if (st.seq_end)     state_d = ST_DIV_GO;
					else                     state_d = ST_SCAN;
				end
			end
			ST_SPACE: begin
				if (out_fire) begin
					priority if (pend_label_q) state_d = ST_LABEL;
					else if (pend_end_q)       state_d = ST_DIV_GO;
					else                       state_d = ST_SCAN;
				end
			end
			ST_LABEL: begin
				if (out_fire)
					state_d = pend_end_q ? ST_DIV_GO : ST_SCAN;
			end
			ST_DIV_GO:  state_d = ST_DIV_RUN;
			ST_DIV_RUN: begin
				if (!st.div_busy)
					state_d = ST_END;
			end
			ST_END: begin
				if (out_fire)
					state_d = ST_SCAN;
			end
			default:    state_d = ST_SCAN;
		endcase
	end

	always_comb begin
		unique case (state_d)
			ST_SPACE: kind_d = KIND_SPACE;
			ST_END:   kind_d = KIND_END;
			default:  kind_d = KIND_LABEL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SCAN;
			pend_label_q <= 1'b0;
			pend_end_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			last_q       <= 1'b0;
			kind_q       <= KIND_LABEL;
		end else begin
			state_q     <= state_d;
			out_valid_q <= (state_d == ST_SPACE) || (state_d == ST_LABEL) ||
				(state_d == ST_END);
			last_q      <= state_d == ST_END;
			kind_q      <= kind_d;
			if (take && st.row_end) begin
				pend_label_q <= st.label;
				pend_end_q   <= st.seq_end;
			end
		end
	end

	assign cmd.take      = take;
	assign cmd.seq_close = state_q == ST_DIV_GO;
	assign cmd.kind      = kind_q;
	assign in_stall      = state_q != ST_SCAN;
	assign out_valid     = out_valid_q;
	assign token_kind    = kind_q;
	assign last          = last_q;

	// no request is taken while a result is offered
	`CTCGD_ASSERT_IMP(a_no_overlap, !in_stall, !out_valid)
	// only the end result carries last
	`CTCGD_ASSERT_IMP(a_last_kind, out_valid && last, token_kind == KIND_END)
	// a row end with results closes the input
	`CTCGD_ASSERT_NXT(a_row_hold, take && st.row_end && any_result, in_stall)
	// the divider runs once the sequence is closed
	`CTCGD_ASSERT_NXT(a_div_run, cmd.seq_close, st.div_busy)

endmodule

`default_nettype wire

[test/ctc_greedy_decoder_tb.sv]
`timescale 1ns / 1ps

module ctc_greedy_decoder_tb;
	import ctcgd_pkg::*;

	localparam int SCORE_W      = DEF_SCORE_BITS;
	// divider pass at a sequence end plus some slack for the result registers
	localparam int QUIET_CYCLES = 40;

	typedef struct packed {
		kind_t              kind;
		logic [LABEL_W-1:0] label;
		logic [MEAN_W-1:0]  mean;
		logic               last;
	} token_t;

	// block ports
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_reg_t              cfg_index = REG_CLASS_COUNT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [SCORE_W-1:0]    class_score = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [KIND_W-1:0]     token_kind;
	logic [LABEL_W-1:0]    label_index;
	logic [MEAN_W-1:0]     mean_score;
	logic                  last;

	// idle rates in percent, and the long output hold-off counter
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_left = 0;
	int unsigned fail_count = 0;

	// predicted token stream, oldest first
	token_t pending_tokens[$];

	// decoder register copy
	logic [CLASS_CFG_W-1:0] class_cfg = CLASS_COUNT_RST;
	logic [CLASS_CFG_W-1:0] label_cfg = LABEL_COUNT_RST;
	logic [STEP_CFG_W-1:0]  step_cfg  = STEP_COUNT_RST;
	logic [STEP_CFG_W-1:0]  gap_cfg   = GAP_RST;

	// decoder sequence state copy
	logic [LABEL_W-1:0]     class_pos = '0;
	logic [9:0]             step_pos = '0;
	logic [SCORE_W-1:0]     best_score = '0;
	logic [LABEL_W-1:0]     best_class = '0;
	logic [CLASS_CFG_W-1:0] prev_class = NO_CLASS;
	logic [RUN_W-1:0]       blank_run = '0;
	logic [RUN_W-1:0]       emitted_count = '0;
	logic [25:0]            score_sum = '0;

	ctc_greedy_decoder i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.class_score (class_score),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.token_kind  (token_kind),
		.label_index (label_index),
		.mean_score  (mean_score),
		.last        (last)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// decoder prediction
	// ---------------------------------------------------------------------

	function automatic void add_token(input kind_t k, input logic [LABEL_W-1:0] lbl,
			input logic [MEAN_W-1:0] avg, input logic fin);
		token_t t;
		t.kind  = k;
		t.label = lbl;
		t.mean  = avg;
		t.last  = fin;
		pending_tokens = {pending_tokens, t};
	endfunction

	function automatic void clear_sequence_state();
		class_pos     = '0;
		step_pos      = '0;
		best_score    = '0;
		best_class    = '0;
		prev_class    = NO_CLASS;
		blank_run     = '0;
		emitted_count = '0;
		score_sum     = '0;
	endfunction

	function automatic void apply_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_CLASS_COUNT:   class_cfg = d;
			REG_LABEL_COUNT:   label_cfg = d;
			REG_STEP_COUNT:    step_cfg  = d[STEP_CFG_W-1:0];
			REG_GAP_THRESHOLD: gap_cfg   = d[STEP_CFG_W-1:0];
			default: ;
		endcase
	endfunction

	// one accepted score; pushes whatever tokens it completes
	function automatic void track_score(input logic [SCORE_W-1:0] s);
		int unsigned classes;
		int unsigned steps;
		logic [MEAN_W-1:0] avg;
		// zero acts as one, oversized counts clamp to the build maxima
		classes = (class_cfg == 0) ? 1 :
			((class_cfg > DEF_MAX_CLASSES) ? DEF_MAX_CLASSES : class_cfg);
		steps = (step_cfg == 0) ? 1 : ((step_cfg > DEF_MAX_STEPS) ? DEF_MAX_STEPS : step_cfg);

		// first maximum of the row wins, ties keep the lower class
		if (class_pos == 0 || s > best_score) begin
			best_score = s;
			best_class = class_pos;
		end
		if (class_pos + 1 < classes) begin
			class_pos = class_pos + 1'b1;
			return;
		end
		class_pos = '0;

		if (best_class == 0) begin
			// blank step, run length saturates
			if (blank_run != RUN_MAX)
				blank_run = blank_run + 1'b1;
		end else begin
			// long blank gap after some label becomes a space
			if (blank_run > gap_cfg && emitted_count != 0)
				add_token(KIND_SPACE, '0, '0, 1'b0);
			blank_run = '0;
			// out-of-range winners still end the gap but never emit
			if (best_class < label_cfg && {1'b0, best_class} != prev_class) begin
				add_token(KIND_LABEL, best_class, '0, 1'b0);
				score_sum = score_sum + best_score;
				if (emitted_count != RUN_MAX)
					emitted_count = emitted_count + 1'b1;
			end
		end
		prev_class = {1'b0, best_class};

		if (step_pos + 1 < steps) begin
			step_pos = step_pos + 1'b1;
			return;
		end

		// mean rounded half up, zero when nothing was emitted
		avg = '0;
		if (emitted_count != 0)
			avg = MEAN_W'((32'(score_sum) + 32'(emitted_count) / 2) / 32'(emitted_count));
		add_token(KIND_END, '0, avg, 1'b1);
		clear_sequence_state();
	endfunction

	// ---------------------------------------------------------------------
	// checking
	// ---------------------------------------------------------------------

	function automatic void note_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		fail_count++;
	endfunction

	function automatic void check_token();
		token_t want;
		if (pending_tokens.size() == 0) begin
			$display("%0t: unexpected result, expected none, %s %0d %0d %0d %0d",
				$time, "actual kind label mean last", token_kind, label_index,
				mean_score, last);
			fail_count++;
			return;
		end
		want = pending_tokens.pop_front();
		if (token_kind !== want.kind)
			note_mismatch("token_kind", want.kind, token_kind);
		if (label_index !== want.label)
			note_mismatch("label_index", want.label, label_index);
		if (mean_score !== want.mean)
			note_mismatch("mean_score", want.mean, mean_score);
		if (last !== want.last)
			note_mismatch("last", want.last, last);
	endfunction

	// every handshake is observed at the rising edge, before the block updates
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				apply_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				track_score(class_score);
			if (out_valid && !out_stall)
				check_token();
		end
	end

	// receiver side: random stall, or a counted hold-off when one is pending
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_stall = 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall = ($urandom_range(99, 0) < recv_idle_pct);
		end
	end

	// ---------------------------------------------------------------------
	// stimulus helpers, all entered and left just after a falling edge
	// ---------------------------------------------------------------------

	// one score request; valid stays up afterwards so back-to-back requests flow
	task automatic send_score(input logic [SCORE_W-1:0] s);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		class_score = s;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// one time step steered toward a winner; later classes may tie the top score
	task automatic send_row(input int unsigned classes, input int unsigned winner,
			input int unsigned top);
		int unsigned peak;
		peak = (winner != 0 && top == 0) ? 1 : top;
		for (int c = 0; c < classes; c++) begin
			if (c == winner)
				send_score(SCORE_W'(peak));
			else if (c < winner)
				send_score(SCORE_W'($urandom_range(peak - 1, 0)));
			else
				send_score(SCORE_W'($urandom_range(peak, 0)));
		end
	endtask

	// four explicit scores, class 0 leftmost
	task automatic send_row4(input logic [3:0][SCORE_W-1:0] r);
		for (int i = 3; i >= 0; i--)
			send_score(r[i]);
	endtask

	// top score biased toward the extremes
	function automatic int unsigned pick_top();
		case ($urandom_range(3, 0))
			0:       return 65535;
			1:       return $urandom_range(15, 0);
			default: return $urandom_range(65535, 0);
		endcase
	endfunction

	// drop valid, drain every predicted token, then let the divider finish
	task automatic settle();
		in_valid = 1'b0;
		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_reg(input cfg_reg_t r, input int unsigned v);
		cfg_valid = 1'b1;
		cfg_index = r;
		cfg_data  = CFG_DATA_W'(v);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic configure(input int unsigned classes, input int unsigned labels,
			input int unsigned steps, input int unsigned gap);
		settle();
		set_reg(REG_CLASS_COUNT, classes);
		set_reg(REG_LABEL_COUNT, labels);
		set_reg(REG_STEP_COUNT, steps);
		set_reg(REG_GAP_THRESHOLD, gap);
	endtask

	// ---------------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------------

	// all-zero and all-max rows, ties, winner on the last class;
	// label count and gap threshold stay at their reset values
	task automatic test_ties_and_score_extremes();
		settle();
		set_reg(REG_CLASS_COUNT, 4);
		set_reg(REG_STEP_COUNT, 3);
		send_row4({16'd0, 16'd0, 16'd0, 16'd0});
		send_row4({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
		send_row4({16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF});
		send_row4({16'd1, 16'd2, 16'd2, 16'd1});
		send_row4({16'hFFFF, 16'd0, 16'd0, 16'hFFFE});
		send_row4({16'd0, 16'd0, 16'd0, 16'd1});
	endtask

	// repeats, out-of-range winners, empty label range, mean rounding
	task automatic test_labels_and_mean();
		configure(3, 2, 7, 0);
		send_row(3, 1, 1);
		send_row(3, 1, 5);     // same class again, no label
		send_row(3, 2, 9);     // above label range, still becomes previous
		send_row(3, 1, 2);
		send_row(3, 0, 40);
		send_row(3, 1, 3);     // space then label after a one-step gap
		send_row(3, 0, 0);
		// nothing emittable, mean must be zero
		configure(3, 0, 3, 5);
		send_row(3, 1, 100);
		send_row(3, 2, 200);
		send_row(3, 0, 300);
		// widest label range, mean of 1 and 2 rounds up
		configure(3, 16383, 2, 0);
		send_row(3, 1, 1);
		send_row(3, 2, 2);
	endtask

	// blank runs around the gap threshold
	task automatic test_gap_spaces();
		int unsigned pattern[15];
		// leading blanks give no space, later runs of three do, a run of two does not;
		// the final step yields space, label and end together
		pattern = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 1, 0, 0, 0, 1};
		configure(2, 2, 15, 2);
		foreach (pattern[i])
			send_row(2, pattern[i], pick_top());
		configure(2, 2, 6, 2047);
		send_row(2, 1, 7);
		repeat (4) send_row(2, 0, pick_top());
		send_row(2, 1, 9);
		configure(2, 2, 4, 1024);
		send_row(2, 1, 7);
		send_row(2, 0, 7);
		send_row(2, 0, 7);
		send_row(2, 1, 7);
		// a winner above the label range still triggers the space
		configure(3, 2, 5, 0);
		send_row(3, 1, 11);
		send_row(3, 0, 12);
		send_row(3, 2, 13);
		send_row(3, 0, 14);
		send_row(3, 1, 15);
	endtask

	// register extremes: zero counts, single-class rows, full-scale label scores
	task automatic test_register_extremes();
		configure(0, 8192, 5, 1);
		repeat (5) send_score(SCORE_W'($urandom_range(65535, 0)));
		configure(1, 1, 3, 0);
		repeat (3) send_score(SCORE_W'($urandom_range(65535, 0)));
		// full-scale labels every step, mean stays at the top score
		configure(3, 3, 4, 0);
		for (int k = 0; k < 4; k++)
			send_row(3, (k % 2) + 1, 65535);
		configure(2, 2, 0, 0);
		send_row(2, 1, 7);
		send_row(2, 0, 7);
	endtask

	// random small configurations and mostly steered rows with random content
	task automatic run_random_phase(input int unsigned send_pct, input int unsigned recv_pct,
			input int unsigned item_goal);
		int unsigned sent;
		int unsigned cls_raw;
		int unsigned classes;
		int unsigned stp_raw;
		int unsigned steps;
		int unsigned winner;
		int unsigned last_winner;
		int unsigned pick;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		sent = 0;
		last_winner = 0;
		while (sent < item_goal) begin
			cls_raw = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(5, 1);
			classes = (cls_raw == 0) ? 1 : cls_raw;
			stp_raw = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(8, 1);
			steps = (stp_raw == 0) ? 1 : stp_raw;
			configure(cls_raw,
				($urandom_range(4, 0) == 0) ? 16383 : $urandom_range(classes + 1, 0),
				stp_raw,
				($urandom_range(4, 0) == 0) ? $urandom_range(2047, 0) : $urandom_range(3, 0));
			// whole sequences only, so each configuration starts clean
			repeat ($urandom_range(2, 1) * steps) begin
				pick = $urandom_range(9, 0);
				if (pick == 9) begin
					// noise row, no steering at all
					repeat (classes) send_score(SCORE_W'($urandom_range(65535, 0)));
				end else begin
					if (pick < 4)
						winner = 0;
					else if (pick < 6 && last_winner < classes)
						winner = last_winner;
					else
						winner = $urandom_range(classes - 1, 0);
					send_row(classes, winner, pick_top());
					last_winner = winner;
				end
				sent += classes;
			end
		end
	endtask

	// long output hold-off while scores keep coming, so the block backs up
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		configure(2, 2, 8, 0);
		hold_left = 400;
		// label, blank, space plus label ... keeps tokens flowing every other step
		for (int k = 0; k < 16; k++)
			send_row(2, (k % 2 == 0) ? 1 : 0, pick_top());
	endtask

	// ---------------------------------------------------------------------
	// sequencing
	// ---------------------------------------------------------------------

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 17;
		recv_idle_pct = 56;
		test_ties_and_score_extremes();
		test_labels_and_mean();
		test_gap_spaces();
		test_register_extremes();

		run_random_phase(17, 56, 8);
		run_random_phase(56, 17, 8);
		run_random_phase(0, 0, 8);
		test_output_backpressure();

		settle();
		if (fail_count == 0)
			$display("ctc_greedy_decoder_tb passed");
		else
			$display("ctc_greedy_decoder_tb failed");
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin
		#2000000;
		$display("ctc_greedy_decoder_tb failed");
		$finish;
	end

endmodule
